// File: rtl/core/mtsd_pkg.sv
// Shared types and constants for the multi-tap stereo delay.
// Holds the sequencer state enum, the MAC control word and the fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package mtsd_pkg;

  // opcode carried on tuser
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_SET_TAP = 1'b1;

  localparam logic [14:0] CFG_LEN_RESET = 15'd16384;
  localparam logic [12:0] PAN_FULL      = 13'd4096;
  localparam int          OUT_SHIFT     = 24;
  localparam int          MUL_W         = 48;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_TAP,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE,
    ST_MOD_GO,
    ST_MOD_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MS_SAMPLE_GAIN,
    MS_BASE_LEFT,
    MS_BASE_RIGHT
  } mul_sel_t;

  typedef struct packed {
    logic     clear;
    logic     mul_en;
    mul_sel_t sel;
    logic     base_en;
    logic     acc_l_en;
    logic     acc_r_en;
  } mac_ctl_t;

endpackage

// File: rtl/core/mtsd_store.sv
// Circular sample store: one write port, one registered read port.
// Uses no package items.
`timescale 1ns / 1ps

module mtsd_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mtsd_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Uses no package items.
`timescale 1ns / 1ps

module mtsd_mod #(
  parameter int VW = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] remainder
);

  localparam int CNTW = $clog2(VW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   shreg;
  logic [VW-1:0]   rem;
  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;

  assign trial     = {rem, shreg[VW-1]};
  assign diff      = trial - {1'b0, divisor};
  assign ge        = (trial >= {1'b0, divisor});
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(VW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rem stays below divisor, so the trial value is under twice the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

// File: rtl/core/mtsd_mac.sv
// Shared multiplier with left/right accumulators and output saturation.
// Depends on mtsd_pkg (mac_ctl_t, mul_sel_t, PAN_FULL, OUT_SHIFT, MUL_W).
`timescale 1ns / 1ps

module mtsd_mac
  import mtsd_pkg::*;
#(
  parameter int TAP_COUNT = 8
) (
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic signed [15:0] rdata,
  input  logic signed [15:0] gain,
  input  logic [12:0]        pan,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out
);

  localparam int ACC_W = MUL_W + $clog2(TAP_COUNT) + 1;
  localparam int QW    = ACC_W - OUT_SHIFT;

  logic signed [31:0]      mul_a;
  logic signed [15:0]      mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [31:0]      base;
  logic signed [13:0]      lf;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  logic [QW-1:0]           q_l;
  logic [QW-1:0]           q_r;

  // left factor goes negative for pan above full right
  assign lf = $signed({1'b0, PAN_FULL}) - $signed({1'b0, pan});

  always_comb begin
    mul_a = {{16{rdata[15]}}, rdata};
    mul_b = gain;
    case (ctl.sel)
      MS_SAMPLE_GAIN: begin
        mul_a = {{16{rdata[15]}}, rdata};
        mul_b = gain;
      end
      MS_BASE_LEFT: begin
        mul_a = mul_q[31:0];
        mul_b = {{2{lf[13]}}, lf};
      end
      MS_BASE_RIGHT: begin
        mul_a = base;
        mul_b = {3'b000, pan};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_q <= mul_p;
    end
    if (ctl.base_en) begin
      base <= mul_q[31:0];
    end
    if (ctl.clear) begin
      acc_l <= '0;
      acc_r <= '0;
    end else begin
      if (ctl.acc_l_en) begin
        acc_l <= acc_l + {{(ACC_W-MUL_W){mul_q[MUL_W-1]}}, mul_q};
      end
      if (ctl.acc_r_en) begin
        acc_r <= acc_r + {{(ACC_W-MUL_W){mul_q[MUL_W-1]}}, mul_q};
      end
    end
  end

  // arithmetic shift floors; saturate when the upper bits disagree with the sign
  assign q_l = acc_l[ACC_W-1:OUT_SHIFT];
  assign q_r = acc_r[ACC_W-1:OUT_SHIFT];

  always_comb begin
    if (!q_l[QW-1] && (|q_l[QW-2:15])) begin
      left_out = 16'sh7FFF;
    end else if (q_l[QW-1] && !(&q_l[QW-2:15])) begin
      left_out = -16'sh8000;
    end else begin
      left_out = q_l[15:0];
    end
    if (!q_r[QW-1] && (|q_r[QW-2:15])) begin
      right_out = 16'sh7FFF;
    end else if (q_r[QW-1] && !(&q_r[QW-2:15])) begin
      right_out = -16'sh8000;
    end else begin
      right_out = q_r[15:0];
    end
  end

endmodule

// File: rtl/core/multi_tap_stereo_delay_top.sv
// Multi-tap stereo delay: top level with the sequencer and tap registers.
// Depends on mtsd_pkg, mtsd_store, mtsd_mod and mtsd_mac.
//
// Usage:
//  - Input channel s_*: tuser is the opcode. A sample word writes s_tdata's
//    sample into the circular store and yields one stereo word on m_*.
//    A set-tap word loads delay, gain and pan into one tap and yields nothing.
//  - Output channel m_*: tdata holds left (low half) and right (high half).
//  - cfg_we/cfg_wdata set the circular length; write only while idle.
//  - A sample word visits each tap in turn and skips inactive taps; one
//    shared multiplier does three multiplies per active tap. A set-tap
//    word waits on the bit-serial remainder unit that places the read
//    position.
//  - One word is in work at a time; s_tready is high only when idle.
//  - After reset the store is swept to zero with s_tready low;
//    configuration writes are taken during the sweep.
//  - A finished result sits in the output register; the next input word is
//    taken while it waits. A result waiting on a stalled receiver holds the
//    block from finishing its next sample word.
`timescale 1ns / 1ps

module multi_tap_stereo_delay_top
  import mtsd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16384,
  parameter int TAP_COUNT    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] sample_in, [18:16] tap_index, [34:19] tap_delay,
  // [50:35] tap_gain, [63:51] tap_pan
  input  logic [63:0] s_tdata,
  // [0] op
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] left_out, [31:16] right_out
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int TW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int LW = (AW + 1 > 15) ? AW + 1 : 15;
  localparam int CW = (AW + 1 > 16) ? AW + 1 : 16;

  state_t state, state_next;

  logic [14:0] cfg_len;
  logic [LW-1:0] len_full;
  logic [AW:0]   len_eff;

  logic               op_q;
  logic signed [15:0] sample_q;
  logic [2:0]         idx_q;
  logic [15:0]        delay_q;
  logic signed [15:0] gain_q;
  logic [12:0]        pan_q;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] wp;
  logic [AW:0]   wp_inc;
  logic [TW-1:0] ti;
  logic          ti_last;
  logic [TW-1:0] set_idx;
  logic          in_idx_ok;

  logic [AW-1:0]      tap_rp   [TAP_COUNT];
  logic signed [15:0] tap_gain [TAP_COUNT];
  logic [12:0]        tap_pan  [TAP_COUNT];
  logic [TAP_COUNT-1:0] tap_active;
  logic [AW:0]        rp_inc;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic          ge_delay;
  logic [CW-1:0] delay_cw;
  logic [AW:0]   d_eff;
  logic [AW:0]   mod_val;
  logic          mod_start;
  logic          mod_done;
  logic [AW:0]   mod_rem;

  mac_ctl_t           mac_ctl;
  logic signed [15:0] left_res;
  logic signed [15:0] right_res;
  logic               out_free;
  logic               out_load;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= CFG_LEN_RESET;
    end else if (cfg_we) begin
      cfg_len <= cfg_wdata;
    end
  end

  // length clamped to [1, BUFFER_DEPTH]
  always_comb begin
    if (LW'(cfg_len) == '0) begin
      len_full = LW'(1);
    end else if (LW'(cfg_len) > LW'(BUFFER_DEPTH)) begin
      len_full = LW'(BUFFER_DEPTH);
    end else begin
      len_full = LW'(cfg_len);
    end
  end
  assign len_eff = len_full[AW:0];

  // ---- derived values ----
  assign in_idx_ok = (int'(s_tdata[18:16]) < TAP_COUNT);
  assign set_idx   = TW'(idx_q);
  assign ti_last   = (ti == TW'(TAP_COUNT - 1));
  assign wp_inc    = {1'b0, wp} + 1'b1;
  assign rp_inc    = {1'b0, tap_rp[ti]} + 1'b1;
  assign delay_cw  = CW'(delay_q);
  assign ge_delay  = (delay_cw >= CW'(len_eff));
  assign d_eff     = ge_delay ? '0 : delay_cw[AW:0];
  // len - d is at least 1; sum stays below 2*BUFFER_DEPTH
  assign mod_val   = len_eff - d_eff + {1'b0, wp};
  assign out_free  = !m_tvalid || m_tready;

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(BUFFER_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_SAMPLE) begin
            state_next = ST_WRITE;
          end else if (in_idx_ok) begin
            state_next = ST_MOD_GO;
          end
        end
      end
      ST_WRITE: state_next = ST_TAP;
      ST_TAP: begin
        if (tap_active[ti]) begin
          state_next = ST_MUL0;
        end else if (ti_last) begin
          state_next = ST_DONE;
        end
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ti_last ? ST_DONE : ST_TAP;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_MOD_GO: state_next = ST_MOD_WAIT;
      ST_MOD_WAIT: begin
        if (mod_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp;
    mem_wdata = sample_q;
    mem_raddr = tap_rp[ti];
    mod_start = 1'b0;
    out_load  = 1'b0;
    mac_ctl   = '{clear: 1'b0, mul_en: 1'b0, sel: MS_SAMPLE_GAIN,
                  base_en: 1'b0, acc_l_en: 1'b0, acc_r_en: 1'b0};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: s_tready = 1'b1;
      ST_WRITE: begin
        mem_we        = 1'b1;
        mac_ctl.clear = 1'b1;
      end
      ST_MUL0: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.sel    = MS_SAMPLE_GAIN;
      end
      ST_MUL1: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.sel     = MS_BASE_LEFT;
        mac_ctl.base_en = 1'b1;
      end
      ST_MUL2: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.sel      = MS_BASE_RIGHT;
        mac_ctl.acc_l_en = 1'b1;
      end
      ST_MUL3: mac_ctl.acc_r_en = 1'b1;
      ST_DONE: out_load = out_free;
      ST_MOD_GO: mod_start = 1'b1;
      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      wp         <= '0;
      ti         <= '0;
      tap_active <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_WRITE: begin
          wp <= (wp_inc >= len_eff) ? '0 : wp_inc[AW-1:0];
          ti <= '0;
        end
        ST_TAP: begin
          if (!tap_active[ti] && !ti_last) begin
            ti <= ti + 1'b1;
          end
        end
        ST_MUL3: begin
          if (!ti_last) begin
            ti <= ti + 1'b1;
          end
        end
        ST_MOD_WAIT: begin
          if (mod_done) begin
            tap_active[set_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q     <= s_tuser;
      sample_q <= s_tdata[15:0];
      idx_q    <= s_tdata[18:16];
      delay_q  <= s_tdata[34:19];
      gain_q   <= s_tdata[50:35];
      pan_q    <= s_tdata[63:51];
    end
    if (state == ST_MOD_WAIT && mod_done && op_q == OP_SET_TAP) begin
      tap_rp[set_idx]   <= mod_rem[AW-1:0];
      tap_gain[set_idx] <= gain_q;
      tap_pan[set_idx]  <= pan_q;
    end else if (state == ST_MUL3) begin
      tap_rp[ti] <= (rp_inc >= len_eff) ? '0 : rp_inc[AW-1:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {right_res, left_res};
    end
  end

  // ---- units ----
  mtsd_store #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mtsd_mod #(
    .VW (AW + 1)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_val),
    .divisor   (len_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  mtsd_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .rdata     (mem_rdata),
    .gain      (tap_gain[ti]),
    .pan       (tap_pan[ti]),
    .left_out  (left_res),
    .right_out (right_res)
  );

endmodule

// File: rtl/core/mtsd_checker.sv
// Port-level checks for the multi-tap stereo delay, bound to the top level.
// Depends on mtsd_pkg (OP_SAMPLE, OP_SET_TAP).
`timescale 1ns / 1ps

module mtsd_checker
  import mtsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // store sweep follows reset
  a_busy_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

  // a sample word keeps the block busy
  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_SAMPLE) |=> !s_tready)
    else $error("input ready right after a sample word");

  // set-tap word never produces a result
  a_set_tap_silent: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_SET_TAP && !m_tvalid) |=> !m_tvalid)
    else $error("result after a set-tap word");

  // results are loaded only while the input side is closed
  a_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while input was open");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

endmodule

bind multi_tap_stereo_delay_top mtsd_checker u_mtsd_checker (.*);
